// ===== rtl/core/sdc8_pkg.sv =====
// Package for the ChaCha8 keystream block: payload types, constants, helpers.
// No dependencies.
package sdc8_pkg;
  localparam int unsigned Rounds = 8;
  localparam int unsigned RndW = $clog2(Rounds + 1);
  localparam int unsigned AddrW = 6;

  localparam logic [AddrW-1:0] RegKey0 = 6'h00;
  localparam logic [AddrW-1:0] RegKey1 = 6'h08;
  localparam logic [AddrW-1:0] RegKey2 = 6'h10;
  localparam logic [AddrW-1:0] RegKey3 = 6'h18;
  localparam logic [AddrW-1:0] RegNonce = 6'h20;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef struct packed {
    logic       restart;
    logic [6:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word_value;
    logic [3:0]  word_index;
    logic [2:0]  valid_bytes;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StLoad, StRead, StRound, StFeed, StEmit
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  // (x mod 31) + 1 for an 8-bit x: one conditional subtract per fold.
  function automatic logic [4:0] rot_amt(input logic [7:0] x);
    logic [5:0] s;
    s = {1'b0, x[7:5]} + {1'b0, x[4:0]};
    if (s >= 6'd31) s = s - 6'd31;
    return s[4:0] + 5'd1;
  endfunction
endpackage

// ===== rtl/core/sdc8_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port), registered read.
// No dependencies.
module sdc8_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/state_dependent_chacha8_keystream.sv =====
// Top level of the ChaCha8 keystream generator with data-dependent rotation.
// Depends on sdc8_pkg and sdc8_ram.
//
// One request builds one 64-byte keystream block and sends up to 16 words.
// Flow: the load phase writes the input state (sigma, key, counter, nonce)
// into a 16x32 input-state RAM while a register file takes a working copy;
// each of the 8 rounds runs 4 quarter rounds, one per cycle (a quarter round
// is four chained add/xor/rotate steps on a working register); then the feed
// phase reads the input-state RAM back for the feed-forward add, one word per
// cycle, filling the result RAM; then words go out from the result RAM, one
// per cycle while the output is not stalled. A request runs through StLoad,
// StRound, StFeed, StEmit and StRead (which waits for the last word to be
// taken) before StIdle. Each RAM's single read port and the one shared
// quarter-round unit set the pace; output stalls hold the emit phase. A
// request with a zero byte count sends nothing and does not advance the
// counter. No result is pending when the next transaction is taken.
module state_dependent_chacha8_keystream (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [sdc8_pkg::AddrW-1:0] paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sdc8_pkg::in_item_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sdc8_pkg::out_item_t      out_data_o
);
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q, ctr_q;
  logic [31:0] x_q [16];
  sdc8_pkg::state_e st_q, st_d;
  logic [4:0] cnt_q, cnt_d;
  logic [sdc8_pkg::RndW-1:0] rnd_q, rnd_d;
  logic [6:0] n_q, n_d;
  logic ov_q;
  logic [3:0] oi_q;

  assign pready = 1'b1;
  wire wr_en = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0; nonce_q <= '0;
    end else if (wr_en) begin
      case (paddr)
        sdc8_pkg::RegKey0:  key0_q <= pwdata;
        sdc8_pkg::RegKey1:  key1_q <= pwdata;
        sdc8_pkg::RegKey2:  key2_q <= pwdata;
        sdc8_pkg::RegKey3:  key3_q <= pwdata;
        sdc8_pkg::RegNonce: nonce_q <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      sdc8_pkg::RegKey0:  prdata = key0_q;
      sdc8_pkg::RegKey1:  prdata = key1_q;
      sdc8_pkg::RegKey2:  prdata = key2_q;
      sdc8_pkg::RegKey3:  prdata = key3_q;
      sdc8_pkg::RegNonce: prdata = nonce_q;
      default:            prdata = '0;
    endcase
  end

  wire in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != sdc8_pkg::StIdle);
  wire [63:0] ctr_use = in_data_i.restart ? 64'd0 : ctr_q;

  // Input-state word for the load sweep
  logic [31:0] init_w;
  always_comb begin
    case (cnt_q[3:0])
      4'd0: init_w = sdc8_pkg::Sigma0;
      4'd1: init_w = sdc8_pkg::Sigma1;
      4'd2: init_w = sdc8_pkg::Sigma2;
      4'd3: init_w = sdc8_pkg::Sigma3;
      4'd4: init_w = key0_q[31:0];
      4'd5: init_w = key0_q[63:32];
      4'd6: init_w = key1_q[31:0];
      4'd7: init_w = key1_q[63:32];
      4'd8: init_w = key2_q[31:0];
      4'd9: init_w = key2_q[63:32];
      4'd10: init_w = key3_q[31:0];
      4'd11: init_w = key3_q[63:32];
      4'd12: init_w = ctr_q[31:0];
      4'd13: init_w = ctr_q[63:32];
      4'd14: init_w = nonce_q[31:0];
      default: init_w = nonce_q[63:32];
    endcase
  end

  // Quarter-round index selection
  logic [3:0] ia, ib, ic, id;
  logic [1:0] qn;
  always_comb begin
    qn = cnt_q[1:0];
    ia = {2'b00, qn};
    if (!rnd_q[0]) begin
      ib = {2'b01, qn}; ic = {2'b10, qn}; id = {2'b11, qn};
    end else begin
      ib = {2'b01, qn + 2'd1}; ic = {2'b10, qn + 2'd2}; id = {2'b11, qn + 2'd3};
    end
  end
  logic [31:0] qa, qb, qc, qd;
  always_comb begin
    logic [31:0] a, b, c, d;
    a = x_q[ia]; b = x_q[ib]; c = x_q[ic]; d = x_q[id];
    d = sdc8_pkg::rotl(d ^ (a + b), sdc8_pkg::rot_amt(c[7:0] ^ b[7:0]));
    a = a + b;
    c = c + d;
    b = sdc8_pkg::rotl(b ^ c, 5'd12);
    a = a + b;
    d = sdc8_pkg::rotl(d ^ a, 5'd8);
    c = c + d;
    b = sdc8_pkg::rotl(b ^ c, 5'd7);
    qa = a; qb = b; qc = c; qd = d;
  end

  // RAMs: input state and finished block
  logic        st_we, res_we;
  logic [3:0]  st_waddr, st_raddr, res_waddr, res_raddr;
  logic [31:0] st_rdata, res_wdata, res_rdata;
  sdc8_ram #(.Width(32), .Depth(16)) u_state (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(init_w),
    .raddr_i(st_raddr), .rdata_o(st_rdata));
  sdc8_ram #(.Width(32), .Depth(16)) u_res (
    .clk_i, .we_i(res_we), .waddr_i(res_waddr), .wdata_i(res_wdata),
    .raddr_i(res_raddr), .rdata_o(res_rdata));

  wire [3:0] fidx = cnt_q[3:0] - 4'd1;
  assign st_we = (st_q == sdc8_pkg::StLoad);
  assign st_waddr = cnt_q[3:0];
  assign st_raddr = cnt_q[3:0];
  assign res_we = (st_q == sdc8_pkg::StFeed) && (cnt_q != 5'd0);
  assign res_waddr = fidx;
  assign res_wdata = st_rdata + x_q[fidx];

  wire [3:0] last_idx = 4'((n_q - 7'd1) >> 2);
  wire out_acc = out_valid_o && !out_stall_i;
  wire out_free = !ov_q || !out_stall_i;
  // emit: cnt_q is the next word to read; rd_idx_q is the word read last
  // cycle, re-read while the output register is blocked
  logic rd_pend_q;
  logic [3:0] rd_idx_q;
  assign res_raddr = (rd_pend_q && !out_free) ? rd_idx_q : cnt_q[3:0];

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rnd_d = rnd_q; n_d = n_q;
    case (st_q)
      sdc8_pkg::StIdle: if (in_acc && in_data_i.byte_count != 7'd0) begin
        st_d = sdc8_pkg::StLoad; cnt_d = '0;
        n_d = (in_data_i.byte_count > 7'd64) ? 7'd64 : in_data_i.byte_count;
      end
      sdc8_pkg::StLoad: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin st_d = sdc8_pkg::StRound; cnt_d = '0; rnd_d = '0; end
      end
      sdc8_pkg::StRound: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == sdc8_pkg::RndW'(sdc8_pkg::Rounds - 1)) st_d = sdc8_pkg::StFeed;
        end
      end
      sdc8_pkg::StFeed: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin st_d = sdc8_pkg::StEmit; cnt_d = '0; end
      end
      sdc8_pkg::StEmit: begin
        if (!rd_pend_q || out_free) begin
          if (rd_pend_q && rd_idx_q == last_idx) st_d = sdc8_pkg::StRead;
          else cnt_d = cnt_q + 5'd1;
        end
      end
      sdc8_pkg::StRead: if (!ov_q || out_acc) st_d = sdc8_pkg::StIdle;
      default: st_d = sdc8_pkg::StIdle;
    endcase
  end

  wire issue = (st_q == sdc8_pkg::StEmit) && (!rd_pend_q || out_free)
               && !(rd_pend_q && rd_idx_q == last_idx);
  wire take = (st_q == sdc8_pkg::StEmit) && rd_pend_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sdc8_pkg::StIdle; cnt_q <= '0; rnd_q <= '0; n_q <= '0;
      ctr_q <= '0; ov_q <= 1'b0; rd_pend_q <= 1'b0; rd_idx_q <= '0; oi_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; rnd_q <= rnd_d; n_q <= n_d;
      if (in_acc) begin
        if (in_data_i.byte_count != 7'd0) ctr_q <= ctr_use;
        else if (in_data_i.restart) ctr_q <= '0;
      end
      if (st_q == sdc8_pkg::StFeed && cnt_q == 5'd16) ctr_q <= ctr_q + 64'd1;
      if (take) begin
        ov_q <= 1'b1; oi_q <= rd_idx_q;
      end else if (out_acc) ov_q <= 1'b0;
      if (issue) begin rd_pend_q <= 1'b1; rd_idx_q <= cnt_q[3:0]; end
      else if (take) rd_pend_q <= 1'b0;
      if (st_q != sdc8_pkg::StEmit) rd_pend_q <= 1'b0;
    end
  end

  // Working registers: load copy, then quarter-round writeback
  always_ff @(posedge clk_i) begin
    if (st_q == sdc8_pkg::StLoad) x_q[cnt_q[3:0]] <= init_w;
    if (st_q == sdc8_pkg::StRound) begin
      x_q[ia] <= qa; x_q[ib] <= qb; x_q[ic] <= qc; x_q[id] <= qd;
    end
  end

  // Output register; RAM data stays valid while no new read is issued
  logic [31:0] ow_q;
  always_ff @(posedge clk_i) begin
    if (take) ow_q <= res_rdata;
  end
  wire [6:0] left = n_q - {oi_q, 2'b00};
  assign out_valid_o = ov_q;
  assign out_data_o.word_value = ow_q;
  assign out_data_o.word_index = oi_q;
  assign out_data_o.valid_bytes = (left > 7'd4) ? 3'd4 : left[2:0];
  assign out_data_o.last = (oi_q == last_idx);

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != sdc8_pkg::StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (st_q == sdc8_pkg::StEmit || st_q == sdc8_pkg::StRead))
    else $error("result outside emit");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(oi_q)))
    else $error("stalled result changed");
endmodule

// ===== verif/tb_state_dependent_chacha8_keystream.sv =====
// Testbench for the ChaCha8 keystream generator with data-dependent rotation.
// Depends on sdc8_pkg and the state_dependent_chacha8_keystream RTL.
module tb_state_dependent_chacha8_keystream;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: holds its own copy of key, nonce and counter; predicts the
  // keystream words of each accepted request and checks results in order.
  class keystream_board;
    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg;
    logic [63:0] blk_ctr;
    sdc8_pkg::out_item_t pending_words [$];
    int          mismatches;

    function new();
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      nonce_reg = '0;
      blk_ctr = '0;
      mismatches = 0;
    endfunction

    function automatic logic [31:0] rol(logic [31:0] v, int n);
      n = n & 31;
      if (n == 0) return v;
      return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void qround(ref logic [31:0] x[16], input int ia, ib, ic, id);
      logic [31:0] a, b, c, d;
      int r;
      a = x[ia]; b = x[ib]; c = x[ic]; d = x[id];
      a = a + b;
      r = (((c ^ b) & 32'hFF) % 31) + 1;
      d = rol(d ^ a, r);
      c = c + d; b = rol(b ^ c, 12);
      a = a + b; d = rol(d ^ a, 8);
      c = c + d; b = rol(b ^ c, 7);
      x[ia] = a; x[ib] = b; x[ic] = c; x[id] = d;
    endfunction

    // Note one accepted request.
    function void note_request(sdc8_pkg::in_item_t req);
      logic [31:0] init_w [16];
      logic [31:0] x [16];
      int n, words;
      sdc8_pkg::out_item_t w;
      if (req.restart) blk_ctr = '0;
      n = req.byte_count;
      if (n == 0) return;
      if (n > 64) n = 64;
      init_w[0] = sdc8_pkg::Sigma0; init_w[1] = sdc8_pkg::Sigma1;
      init_w[2] = sdc8_pkg::Sigma2; init_w[3] = sdc8_pkg::Sigma3;
      for (int i = 0; i < 4; i++) begin
        init_w[4+2*i] = key_reg[i][31:0];
        init_w[5+2*i] = key_reg[i][63:32];
      end
      init_w[12] = blk_ctr[31:0]; init_w[13] = blk_ctr[63:32];
      init_w[14] = nonce_reg[31:0]; init_w[15] = nonce_reg[63:32];
      x = init_w;
      for (int r = 0; r < sdc8_pkg::Rounds; r++) begin
        if ((r & 1) == 0) begin
          qround(x, 0, 4, 8, 12); qround(x, 1, 5, 9, 13);
          qround(x, 2, 6, 10, 14); qround(x, 3, 7, 11, 15);
        end else begin
          qround(x, 0, 5, 10, 15); qround(x, 1, 6, 11, 12);
          qround(x, 2, 7, 8, 13); qround(x, 3, 4, 9, 14);
        end
      end
      words = (n + 3) / 4;
      for (int k = 0; k < words; k++) begin
        w.word_value = x[k] + init_w[k];
        w.word_index = k[3:0];
        w.valid_bytes = (n - 4*k > 4) ? 3'd4 : 3'(n - 4*k);
        w.last = (k + 1 == words);
        pending_words.push_back(w);
      end
      blk_ctr = blk_ctr + 64'd1;
    endfunction

    // Check one accepted result against the oldest prediction.
    function void check_word(sdc8_pkg::out_item_t got);
      sdc8_pkg::out_item_t exp_w;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = pending_words.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp val=%h idx=%0d vb=%0d last=%b, got val=%h idx=%0d vb=%0d last=%b",
                   exp_w.word_value, exp_w.word_index, exp_w.valid_bytes, exp_w.last,
                   got.word_value, got.word_index, got.valid_bytes, got.last);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [sdc8_pkg::AddrW-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o;
  sdc8_pkg::in_item_t in_data_i;
  logic out_valid_o, out_stall_i;
  sdc8_pkg::out_item_t out_data_o;

  keystream_board board;
  int src_idle_pct, sink_idle_pct;   // idle chance, percent

  state_dependent_chacha8_keystream dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall, check each transaction at the rising edge.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_word(out_data_o);
      @(negedge clk_i);
      out_stall_i = ($urandom_range(99) < sink_idle_pct);
    end
  end

  // APB write: setup cycle then access cycle; pready is always high.
  task automatic write_reg(logic [sdc8_pkg::AddrW-1:0] addr, logic [63:0] data);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (addr)
      sdc8_pkg::RegKey0:  board.key_reg[0] = data;
      sdc8_pkg::RegKey1:  board.key_reg[1] = data;
      sdc8_pkg::RegKey2:  board.key_reg[2] = data;
      sdc8_pkg::RegKey3:  board.key_reg[3] = data;
      sdc8_pkg::RegNonce: board.nonce_reg = data;
      default: ;
    endcase
  endtask

  // Send one request; valid holds until the transaction is taken.
  task automatic send_request(logic rst_flag, logic [6:0] cnt);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i.restart = rst_flag;
    in_data_i.byte_count = cnt;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(in_data_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait for every predicted word, then enough cycles for a zero-count
  // request (no words) to drain out of the pipeline.
  task automatic drain();
    while (board.pending_words.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic random_keys();
    write_reg(sdc8_pkg::RegKey0, {$urandom, $urandom});
    write_reg(sdc8_pkg::RegKey1, {$urandom, $urandom});
    write_reg(sdc8_pkg::RegKey2, {$urandom, $urandom});
    write_reg(sdc8_pkg::RegKey3, {$urandom, $urandom});
    write_reg(sdc8_pkg::RegNonce, {$urandom, $urandom});
  endtask

  task automatic random_phase(int n);
    logic [6:0] cnt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       cnt = 7'd0;
        1:       cnt = 7'($urandom_range(127, 65));   // saturates to 64
        2:       cnt = 7'd64;
        default: cnt = 7'($urandom_range(64, 1));
      endcase
      send_request($urandom_range(7) == 0, cnt);
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; in_data_i = '0;
    src_idle_pct = 0; sink_idle_pct = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset key, byte counts across the range, restart cases.
    send_request(1'b0, 7'd64);
    send_request(1'b0, 7'd1);
    send_request(1'b0, 7'd2);
    send_request(1'b0, 7'd3);
    send_request(1'b0, 7'd4);
    send_request(1'b0, 7'd5);
    send_request(1'b0, 7'd63);
    send_request(1'b0, 7'd0);     // no words, counter holds
    send_request(1'b1, 7'd0);     // restart with no words
    send_request(1'b0, 7'd127);   // saturates to a full block
    send_request(1'b1, 7'd65);
    drain();

    // All-ones key and nonce; counter wrap needs 2^64 blocks, not reachable.
    write_reg(sdc8_pkg::RegKey0, '1); write_reg(sdc8_pkg::RegKey1, '1);
    write_reg(sdc8_pkg::RegKey2, '1); write_reg(sdc8_pkg::RegKey3, '1);
    write_reg(sdc8_pkg::RegNonce, '1);
    send_request(1'b1, 7'd64);
    send_request(1'b0, 7'd42);
    send_request(1'b0, 7'd64);
    drain();

    // Random phases with the idling pattern.
    random_keys();
    src_idle_pct = 6; sink_idle_pct = 54;
    random_phase(40);
    drain();
    random_keys();
    src_idle_pct = 54; sink_idle_pct = 6;
    random_phase(40);
    drain();
    random_keys();
    src_idle_pct = 0; sink_idle_pct = 0;
    random_phase(36);
    drain();

    if (board.mismatches == 0 && board.pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== state_dependent_chacha8_keystream.f =====
rtl/core/sdc8_pkg.sv
rtl/core/sdc8_ram.sv
rtl/core/state_dependent_chacha8_keystream.sv
verif/tb_state_dependent_chacha8_keystream.sv
